// ----- rtl/rgbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbc_pkg
// shared types and constants for the rotating grid byte cipher
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int OP_W       = 3;
    localparam int GRID_DEPTH = 256;
    localparam int NIB_DEPTH  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ENCODE    = 3'd0,
        OP_DECODE    = 3'd1,
        OP_LOAD_GRID = 3'd2,
        OP_LOAD_COL  = 3'd3,
        OP_LOAD_ROW  = 3'd4
    } t_op;

    // write request into the column and row nibble tables
    typedef struct packed {
        logic             col_we;
        logic             row_we;
        logic [NIB_W-1:0] idx;
        logic [NIB_W-1:0] val;
    } t_nib_wr;

endpackage

// ----- rtl/rgbc_in_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_in_if
// input word channel: operation, data byte, table slot, restart flag
// ----------------------------------------------------------------------------
interface rgbc_in_if;
    import rgbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_in;
    logic [BYTE_W-1:0] table_index;
    logic              restart;

    modport source (output valid, operation, data_in, table_index, restart, input ready);
    modport sink   (input valid, operation, data_in, table_index, restart, output ready);
endinterface

// ----- rtl/rgbc_out_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_out_if
// result word channel: encoded or decoded byte
// ----------------------------------------------------------------------------
interface rgbc_out_if;
    import rgbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;

    modport source (output valid, data_out, input ready);
    modport sink   (input valid, data_out, output ready);
endinterface

// ----- rtl/rgbc_ram.sv -----
// ----------------------------------------------------------------------------
// rgbc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rgbc_ram #(
    parameter int WIDTH = rgbc_pkg::BYTE_W,
    parameter int DEPTH = rgbc_pkg::GRID_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rgbc_nib_tables.sv -----
// ----------------------------------------------------------------------------
// rgbc_nib_tables
// column and row nibble permutations with their inverses
// ----------------------------------------------------------------------------
module rgbc_nib_tables (
    input  logic                       i_clk,
    input  rgbc_pkg::t_nib_wr          i_wr,
    input  logic [rgbc_pkg::NIB_W-1:0] i_enc_col_addr,
    input  logic [rgbc_pkg::NIB_W-1:0] i_enc_row_addr,
    input  logic [rgbc_pkg::NIB_W-1:0] i_dec_col_addr,
    input  logic [rgbc_pkg::NIB_W-1:0] i_dec_row_addr,
    output logic [rgbc_pkg::NIB_W-1:0] o_enc_col,
    output logic [rgbc_pkg::NIB_W-1:0] o_enc_row,
    output logic [rgbc_pkg::NIB_W-1:0] o_dec_col,
    output logic [rgbc_pkg::NIB_W-1:0] o_dec_row
);
    import rgbc_pkg::*;

    logic [NIB_W-1:0] r_col_perm [NIB_DEPTH];
    logic [NIB_W-1:0] r_col_inv  [NIB_DEPTH];
    logic [NIB_W-1:0] r_row_perm [NIB_DEPTH];
    logic [NIB_W-1:0] r_row_inv  [NIB_DEPTH];

    // each load writes the entry and the matching inverse entry
    always_ff @(posedge i_clk) begin
        if (i_wr.col_we) begin
            r_col_perm[i_wr.idx] <= i_wr.val;
            r_col_inv[i_wr.val]  <= i_wr.idx;
        end
        if (i_wr.row_we) begin
            r_row_perm[i_wr.idx] <= i_wr.val;
            r_row_inv[i_wr.val]  <= i_wr.idx;
        end
    end

    assign o_enc_col = r_col_perm[i_enc_col_addr];
    assign o_enc_row = r_row_perm[i_enc_row_addr];
    assign o_dec_col = r_col_inv[i_dec_col_addr];
    assign o_dec_row = r_row_inv[i_dec_row_addr];
endmodule

// ----- rtl/rotating_grid_byte_cipher.sv -----
// ----------------------------------------------------------------------------
// rotating_grid_byte_cipher
// byte stream cipher over a 16x16 grid with rotating column and row keys
// ----------------------------------------------------------------------------
//
//  channel  | dir | words                                       | handshake
//  ---------+-----+---------------------------------------------+-------------
//  i_in     | in  | operation, data_in, table_index, restart    | valid/ready
//  o_out    | out | data_out, one per encode or decode word     | valid/ready
//
//  one word per cycle sustained while o_out is ready; a result passes through the
//  registered grid ram read and then the output register
//  loads write the tables at the accepting edge, so a following word sees them
//  reset clears the stream position and pipeline valids; tables are unset until
//  loaded
//  a stall on o_out backs up through the grid stage and then drops i_in.ready
//
module rotating_grid_byte_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgbc_in_if.sink    i_in,
    rgbc_out_if.source o_out
);
    import rgbc_pkg::*;

    localparam int GA_W = $clog2(GRID_DEPTH);

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic r_s1_valid;    // grid read stage holds an encode or decode word
    logic r_out_valid;   // output register holds a result
    logic s1_move;
    logic in_ready;
    logic accept;
    logic is_enc;
    logic is_dec;
    t_op  op;

    assign op       = t_op'(i_in.operation);
    assign s1_move  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_move;
    assign accept   = i_in.valid && in_ready;

    always_comb begin
        is_enc = 1'b0;
        is_dec = 1'b0;
        case (op)
            OP_ENCODE: is_enc = 1'b1;
            OP_DECODE: is_dec = 1'b1;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // stream position
    // ------------------------------------------------------------------
    logic [NIB_W-1:0] r_pos;
    logic [NIB_W-1:0] n_pos;
    logic [NIB_W-1:0] cur_pos;   // position used by this word

    assign cur_pos = i_in.restart ? '0 : r_pos;

    always_comb begin
        n_pos = r_pos;
        if (accept && (is_enc || is_dec)) begin
            n_pos = cur_pos + NIB_W'(1);   // wraps at 16
        end
    end

    // ------------------------------------------------------------------
    // table writes
    // ------------------------------------------------------------------
    t_nib_wr nib_wr;
    logic    grid_we;

    always_comb begin
        nib_wr.col_we = 1'b0;
        nib_wr.row_we = 1'b0;
        nib_wr.idx    = i_in.table_index[NIB_W-1:0];
        nib_wr.val    = i_in.data_in[NIB_W-1:0];
        grid_we       = 1'b0;
        if (accept) begin
            case (op)
                OP_LOAD_GRID: grid_we       = 1'b1;
                OP_LOAD_COL:  nib_wr.col_we = 1'b1;
                OP_LOAD_ROW:  nib_wr.row_we = 1'b1;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // nibble tables: decode inverse lookups at accept, encode lookups in s1
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] grid_inv_q;   // grid position of the byte being encoded
    logic [NIB_W-1:0]  r_s1_pos;
    logic              r_s1_enc;
    logic [NIB_W-1:0]  enc_col_addr;
    logic [NIB_W-1:0]  enc_row_addr;
    logic [NIB_W-1:0]  enc_col;
    logic [NIB_W-1:0]  enc_row;
    logic [NIB_W-1:0]  dec_col;
    logic [NIB_W-1:0]  dec_row;

    // rotate the grid column and row by the stream position
    assign enc_col_addr = grid_inv_q[NIB_W-1:0] + r_s1_pos;
    assign enc_row_addr = grid_inv_q[BYTE_W-1:NIB_W] + r_s1_pos;

    rgbc_nib_tables u_nib_tables (
        .i_clk          (i_clk),
        .i_wr           (nib_wr),
        .i_enc_col_addr (enc_col_addr),
        .i_enc_row_addr (enc_row_addr),
        .i_dec_col_addr (i_in.data_in[BYTE_W-1:NIB_W]),
        .i_dec_row_addr (i_in.data_in[NIB_W-1:0]),
        .o_enc_col      (enc_col),
        .o_enc_row      (enc_row),
        .o_dec_col      (dec_col),
        .o_dec_row      (dec_row)
    );

    // decode: undo the rotation, then the grid cell is {row, column}
    logic [NIB_W-1:0] dec_ic;
    logic [NIB_W-1:0] dec_ir;
    logic [GA_W-1:0]  dec_addr;

    assign dec_ic   = dec_col - cur_pos;
    assign dec_ir   = dec_row - cur_pos;
    assign dec_addr = GA_W'({dec_ir, dec_ic});

    // ------------------------------------------------------------------
    // grid ram and its inverse, both read only by an accepted word
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] grid_perm_q;

    rgbc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid_perm (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (GA_W'(i_in.table_index)),
        .i_wdata (i_in.data_in),
        .i_re    (accept && is_dec),
        .i_raddr (dec_addr),
        .o_rdata (grid_perm_q)
    );

    rgbc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid_inv (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (GA_W'(i_in.data_in)),
        .i_wdata (i_in.table_index),
        .i_re    (accept && is_enc),
        .i_raddr (GA_W'(i_in.data_in)),
        .o_rdata (grid_inv_q)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic              n_s1_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [BYTE_W-1:0] s1_result;

    assign s1_result = r_s1_enc ? {enc_col, enc_row} : grid_perm_q;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = is_enc || is_dec;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= cur_pos;
            r_s1_enc <= is_enc;
        end
        if (s1_move) begin
            r_out_data <= s1_result;
        end
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rotating grid byte cipher: random key tables are
// loaded first, then directed and random word streams run through the block
// with random idling on both channels; a predictor of the key
// tables and stream position supplies the expected byte for every encode
// and decode word
// ----------------------------------------------------------------------------
module testbench;
    import rgbc_pkg::*;

    // operation codes the block must ignore
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    localparam int RESET_CYCLES      = 6;
    localparam int HOLD_CYCLES       = 100;
    localparam int WATCHDOG_LIMIT    = 1000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int MAX_REPORTS       = 10;
    localparam int RANDOM_WORD_GOAL  = 480;
    localparam int TOTAL_WORD_GOAL   = 545;

    logic clk = 1'b0;
    logic rst_n;

    rgbc_in_if  in_if ();
    rgbc_out_if out_if ();

    rotating_grid_byte_cipher DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // cipher predictor: key tables, their inverses and the stream position
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] grid_fwd [GRID_DEPTH];
    logic [BYTE_W-1:0] grid_rev [GRID_DEPTH];
    logic [NIB_W-1:0]  col_fwd  [NIB_DEPTH];
    logic [NIB_W-1:0]  col_rev  [NIB_DEPTH];
    logic [NIB_W-1:0]  row_fwd  [NIB_DEPTH];
    logic [NIB_W-1:0]  row_rev  [NIB_DEPTH];
    logic [NIB_W-1:0]  stream_pos = '0;

    logic [BYTE_W-1:0] expected_bytes [$];
    logic [BYTE_W-1:0] last_result;
    logic [BYTE_W-1:0] wanted_byte;

    int  fault_count = 0;
    int  words_sent  = 0;
    int  idle_cycles = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    bit  hold_request = 1'b0;

    // applies one accepted word to the predicted state, queues its byte if any
    function automatic void cipher_step(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                        logic [BYTE_W-1:0] idx, logic rst_pos);
        logic [BYTE_W-1:0] spot;
        logic [BYTE_W-1:0] outb;
        logic [NIB_W-1:0]  ci;
        logic [NIB_W-1:0]  ri;
        case (op)
            OP_ENCODE, OP_DECODE: begin
                if (rst_pos)
                    stream_pos = '0;
                if (op == OP_ENCODE) begin
                    // grid position, then both coordinates rotate by the position
                    spot = grid_rev[data];
                    ci   = spot[3:0] + stream_pos;
                    ri   = spot[7:4] + stream_pos;
                    outb = {col_fwd[ci], row_fwd[ri]};
                end else begin
                    ci   = col_rev[data[7:4]] - stream_pos;
                    ri   = row_rev[data[3:0]] - stream_pos;
                    outb = grid_fwd[{ri, ci}];
                end
                stream_pos = stream_pos + 1'b1;
                expected_bytes.push_back(outb);
                last_result = outb;
            end
            OP_LOAD_GRID: begin
                grid_fwd[idx]  = data;
                grid_rev[data] = idx;
            end
            OP_LOAD_COL: begin
                col_fwd[idx[3:0]]  = data[3:0];
                col_rev[data[3:0]] = idx[3:0];
            end
            OP_LOAD_ROW: begin
                row_fwd[idx[3:0]]  = data[3:0];
                row_rev[data[3:0]] = idx[3:0];
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // word sender: optional idle burst, then hold the word until taken
    // ------------------------------------------------------------------------
    task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                             logic [BYTE_W-1:0] idx, logic rst_pos);
        if (send_idle_on && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= op;
        in_if.data_in     <= data;
        in_if.table_index <= idx;
        in_if.restart     <= rst_pos;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        cipher_step(op, data, idx, rst_pos);
        words_sent++;
    endtask

    // sender goes quiet until every pending byte has come back
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: data_out %02h with no word pending", $time,
                             out_if.data_out);
            end else begin
                wanted_byte = expected_bytes.pop_front();
                if (out_if.data_out !== wanted_byte) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: data_out expected %02h, got %02h", $time,
                                 wanted_byte, out_if.data_out);
                end
            end
        end
    end

    // result receiver: random stall bursts, plus one long hold on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------------
    // encode a short run from position zero, then decode the cipher text back
    task automatic run_round_trip(int len);
        logic [BYTE_W-1:0] sealed [$];
        for (int k = 0; k < len; k++) begin
            send_word(OP_ENCODE, 8'($urandom), 8'($urandom), k == 0);
            sealed.push_back(last_result);
        end
        for (int k = 0; k < len; k++)
            send_word(OP_DECODE, sealed[k], 8'($urandom), k == 0);
    endtask

    // exchange two entries of one key table, which keeps it a permutation
    task automatic swap_key_entries(logic [OP_W-1:0] op);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] va;
        logic [BYTE_W-1:0] vb;
        a = 8'($urandom);
        b = 8'($urandom);
        case (op)
            OP_LOAD_GRID: begin
                va = grid_fwd[a];
                vb = grid_fwd[b];
            end
            OP_LOAD_COL: begin
                va = {4'($urandom), col_fwd[a[3:0]]};
                vb = {4'($urandom), col_fwd[b[3:0]]};
            end
            default: begin
                va = {4'($urandom), row_fwd[a[3:0]]};
                vb = {4'($urandom), row_fwd[b[3:0]]};
            end
        endcase
        send_word(op, vb, a, 1'($urandom));
        send_word(op, va, b, 1'($urandom));
    endtask

    // mixed encode and decode of arbitrary bytes with the odd restart
    task automatic run_free_stream(int len);
        for (int k = 0; k < len; k++)
            send_word($urandom_range(0, 1) ? OP_DECODE : OP_ENCODE, 8'($urandom),
                      8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic send_random_segment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            run_round_trip($urandom_range(1, 20));
        else if (pick < 65)
            swap_key_entries(3'($urandom_range(OP_LOAD_GRID, OP_LOAD_ROW)));
        else if (pick < 85)
            run_free_stream($urandom_range(4, 12));
        else if (pick < 95)
            // arbitrary load, may break the permutation property
            send_word(3'($urandom_range(OP_LOAD_GRID, OP_LOAD_ROW)), 8'($urandom),
                      8'($urandom), 1'($urandom));
        else
            send_word(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), 8'($urandom),
                      8'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // full random permutations into all three tables, so no lookup ever
    // touches an entry that was never written
    task automatic test_load_keys();
        logic [BYTE_W-1:0] grid_key [GRID_DEPTH];
        logic [NIB_W-1:0]  col_key [NIB_DEPTH];
        logic [NIB_W-1:0]  row_key [NIB_DEPTH];
        logic [BYTE_W-1:0] t8;
        logic [NIB_W-1:0]  t4;
        int j;
        for (int i = 0; i < GRID_DEPTH; i++)
            grid_key[i] = 8'(i);
        for (int i = 0; i < NIB_DEPTH; i++) begin
            col_key[i] = 4'(i);
            row_key[i] = 4'(i);
        end
        for (int i = GRID_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t8 = grid_key[i]; grid_key[i] = grid_key[j]; grid_key[j] = t8;
        end
        for (int i = NIB_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t4 = col_key[i]; col_key[i] = col_key[j]; col_key[j] = t4;
            j = $urandom_range(0, i);
            t4 = row_key[i]; row_key[i] = row_key[j]; row_key[j] = t4;
        end
        for (int i = 0; i < GRID_DEPTH; i++)
            send_word(OP_LOAD_GRID, grid_key[i], 8'(i), 1'($urandom));
        // nibble loads carry junk in the upper bits, which must be dropped
        for (int i = 0; i < NIB_DEPTH; i++) begin
            send_word(OP_LOAD_COL, {4'($urandom), col_key[i]}, {4'($urandom), 4'(i)},
                      1'($urandom));
            send_word(OP_LOAD_ROW, {4'($urandom), row_key[i]}, {4'($urandom), 4'(i)},
                      1'($urandom));
        end
    endtask

    // extreme bytes both ways, run long enough for the position to wrap
    task automatic test_extremes_and_wrap();
        for (int k = 0; k <= NIB_DEPTH; k++)
            send_word(k[0] ? OP_DECODE : OP_ENCODE, k[1] ? 8'hff : 8'h00,
                      k[1] ? 8'h00 : 8'hff, k == 0);
    endtask

    // restart on loads is ignored, and nibble slots wrap modulo 16
    task automatic test_special_loads();
        send_word(OP_LOAD_COL, {4'hf, col_fwd[5]}, 8'ha5, 1'b1);
        send_word(OP_LOAD_ROW, {4'h9, row_fwd[2]}, 8'hf2, 1'b1);
        send_word(OP_LOAD_GRID, grid_fwd[255], 8'hff, 1'b1);
        send_word(OP_ENCODE, 8'h5a, 8'h00, 1'b0);
    endtask

    // a duplicate column value leaves a stale inverse entry until restored
    task automatic test_duplicate_key();
        logic [NIB_W-1:0] old3;
        logic [NIB_W-1:0] old7;
        old3 = col_fwd[3];
        old7 = col_fwd[7];
        send_word(OP_LOAD_COL, {4'h0, old7}, 8'h03, 1'b0);
        send_word(OP_DECODE, {old7, 4'($urandom)}, 8'h00, 1'b0);
        send_word(OP_LOAD_COL, {4'h0, old3}, 8'h03, 1'b0);
        send_word(OP_LOAD_COL, {4'h0, old7}, 8'h07, 1'b0);
    endtask

    // unused codes change nothing, not even the position
    task automatic test_unused_ops();
        for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++)
            send_word(3'(op), 8'hff, 8'hff, 1'b1);
        send_word(OP_ENCODE, 8'h3c, 8'h00, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        run_free_stream(24);
        while (hold_request) @(posedge clk);
        send_idle_on = 1'b1;
    endtask

    // sender pauses with the pipeline fully drained, then resumes mid-stream
    task automatic test_drain_pause();
        run_free_stream(6);
        wait_for_results();
        run_free_stream(6);
    endtask

    task automatic test_random_stream();
        while (words_sent < RANDOM_WORD_GOAL)
            send_random_segment();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_no_idle_tail();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        while (words_sent < TOTAL_WORD_GOAL)
            send_random_segment();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n             <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_ENCODE;
        in_if.data_in     <= '0;
        in_if.table_index <= '0;
        in_if.restart     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_keys();
        test_extremes_and_wrap();
        test_special_loads();
        test_duplicate_key();
        test_unused_ops();
        test_backpressure();
        test_drain_pause();
        test_random_stream();
        test_no_idle_tail();

        // let the pipeline empty out, the watchdog bounds this wait
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            fault_count += expected_bytes.size();
            $display("%0d expected bytes never arrived", expected_bytes.size());
        end

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rgbc_pkg.sv
rtl/rgbc_in_if.sv
rtl/rgbc_out_if.sv
rtl/rgbc_ram.sv
rtl/rgbc_nib_tables.sv
rtl/rotating_grid_byte_cipher.sv
tb/testbench.sv
